// File: design/obb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types, constants and helpers for the ray against oriented box
// slab test.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam logic signed [31:0] FX_ONE    = 32'sd65536;
  localparam logic signed [31:0] FAR_BOUND = 32'sd655360000;

  // Quotient bits resolved by the divider, one per stage.
  localparam int DIV_STEPS = 48;
  // Input register, one stage per quotient bit, output register.
  localparam int DIV_LAT   = DIV_STEPS + 2;

  typedef enum logic [1:0] {
    KIND_HIT   = 2'd0,
    KIND_MISS  = 2'd1,
    KIND_UNDEF = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIRECTION_X = 3'd3,
    REG_DIRECTION_Y = 3'd4,
    REG_DIRECTION_Z = 3'd5,
    REG_EPSILON     = 3'd6
  } reg_idx_t;

  // Per box information that travels beside the dividers.
  typedef struct packed {
    logic       v;
    logic [2:0] np;      // axis not parallel: its distances are used
    logic [2:0] pmiss;   // parallel and outside the slab
    logic [2:0] pundef;  // parallel and lying on a face
  } sb_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: design/obb_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obb_div
// Pipelined restoring divider: one quotient bit per stage, truncation
// toward zero and saturation of the quotient to 32 bit signed.
// ----------------------------------------------------------------------------
module obb_div (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic               num_neg,
  input  wire logic [47:0]        num_mag,
  input  wire logic               den_neg,
  input  wire logic [31:0]        den_mag,
  output      logic signed [31:0] quo
);
  import obb_pkg::*;

  logic [31:0] rem_r [DIV_STEPS+1];
  logic [47:0] nq_r  [DIV_STEPS+1];
  logic [31:0] den_r [DIV_STEPS+1];
  logic        neg_r [DIV_STEPS+1];
  logic signed [31:0] quo_r;
  logic signed [31:0] quo_nxt;
  logic [47:0] qm;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= num_mag;
      den_r[0] <= den_mag;
      neg_r[0] <= num_neg ^ den_neg;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [32:0] sh;
    logic        ge;
    logic [32:0] diff;
    assign sh   = {rem_r[i], nq_r[i][47]};
    assign diff = sh - {1'b0, den_r[i]};
    assign ge   = sh >= {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? diff[31:0] : sh[31:0];
        nq_r[i+1]  <= {nq_r[i][46:0], ge};
        den_r[i+1] <= den_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign qm = nq_r[DIV_STEPS];

  always_comb begin
    if (neg_r[DIV_STEPS]) begin
      if (qm > 48'h0000_8000_0000) begin
        quo_nxt = 32'sh80000000;
      end else begin
        quo_nxt = 32'(-qm);
      end
    end else begin
      if (qm > 48'h0000_7FFF_FFFF) begin
        quo_nxt = 32'sh7FFFFFFF;
      end else begin
        quo_nxt = qm[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

// File: design/ray_oriented_box_slab_test_core.sv
`default_nettype none
// A box word passes through 55 register stages from the edge that accepts it
// to the output register from which its result word can be taken.
// Throughput: one box per cycle unless a result waits; the six quotient
// dividers resolve one bit per stage, which sets the depth of the pipeline.
// The whole pipeline advances together and holds while a result waits.
// Reset (rst_n low, synchronous) clears all valid bits and loads the
// registers with origin 0, direction (0, 0, 1.0) and epsilon 66.
// ----------------------------------------------------------------------------
// ray_oriented_box_slab_test_core
// Ray against oriented box slab test in Q16.16 fixed point. The ray is held
// in configuration registers and each input word describes one box.
// ----------------------------------------------------------------------------
module ray_oriented_box_slab_test_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [31:0] in_center_x,
  input  wire logic signed [31:0] in_center_y,
  input  wire logic signed [31:0] in_center_z,
  input  wire logic signed [31:0] in_axis0_x,
  input  wire logic signed [31:0] in_axis0_y,
  input  wire logic signed [31:0] in_axis0_z,
  input  wire logic signed [31:0] in_axis1_x,
  input  wire logic signed [31:0] in_axis1_y,
  input  wire logic signed [31:0] in_axis1_z,
  input  wire logic signed [31:0] in_axis2_x,
  input  wire logic signed [31:0] in_axis2_y,
  input  wire logic signed [31:0] in_axis2_z,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [1:0]         out_hit_kind,
  output      logic signed [31:0] out_hit_distance
);
  import obb_pkg::*;

  // Configuration registers.
  logic signed [31:0] org_r [3];
  logic signed [31:0] dir_r [3];
  logic [15:0]        eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= FX_ONE;
      eps_r    <= 16'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:    org_r[0] <= cfg_data;
        REG_ORIGIN_Y:    org_r[1] <= cfg_data;
        REG_ORIGIN_Z:    org_r[2] <= cfg_data;
        REG_DIRECTION_X: dir_r[0] <= cfg_data;
        REG_DIRECTION_Y: dir_r[1] <= cfg_data;
        REG_DIRECTION_Z: dir_r[2] <= cfg_data;
        REG_EPSILON:     eps_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one: it advances whenever the output register is
  // empty or its word is being taken.
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: relative origin (saturated) and box axes.
  logic               s1_v_r;
  logic signed [31:0] s1_rc_r [3];
  logic signed [31:0] s1_ax_r [3][3];
  logic signed [31:0] ctr [3];
  logic signed [31:0] ax_in [3][3];

  assign ctr[0] = in_center_x;
  assign ctr[1] = in_center_y;
  assign ctr[2] = in_center_z;
  assign ax_in[0][0] = in_axis0_x;
  assign ax_in[0][1] = in_axis0_y;
  assign ax_in[0][2] = in_axis0_z;
  assign ax_in[1][0] = in_axis1_x;
  assign ax_in[1][1] = in_axis1_y;
  assign ax_in[1][2] = in_axis1_z;
  assign ax_in[2][0] = in_axis2_x;
  assign ax_in[2][1] = in_axis2_y;
  assign ax_in[2][2] = in_axis2_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_s1
    always_ff @(posedge clk) begin
      if (en) begin
        s1_rc_r[c]    <= sat32(50'(org_r[c]) - 50'(ctr[c]));
        s1_ax_r[0][c] <= ax_in[0][c];
        s1_ax_r[1][c] <= ax_in[1][c];
        s1_ax_r[2][c] <= ax_in[2][c];
      end
    end
  end

  // Stage 2: the eighteen products, each already floored by 2^16 (taking
  // the upper bits of a two's complement product rounds toward minus
  // infinity, as the dot product requires).
  logic               s2_v_r;
  logic signed [47:0] s2_pd_r [3][3];
  logic signed [47:0] s2_pc_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_s2k
    for (genvar c = 0; c < 3; c++) begin : g_s2c
      logic signed [63:0] pd;
      logic signed [63:0] pc;
      assign pd = 64'(dir_r[c]) * 64'(s1_ax_r[k][c]);
      assign pc = 64'(s1_rc_r[c]) * 64'(s1_ax_r[k][c]);
      always_ff @(posedge clk) begin
        if (en) begin
          s2_pd_r[k][c] <= pd[63:16];
          s2_pc_r[k][c] <= pc[63:16];
        end
      end
    end
  end

  // Stage 3: saturated dot products of direction and relative origin with
  // each axis.
  logic               s3_v_r;
  logic signed [31:0] s3_dn_r [3];
  logic signed [31:0] s3_dc_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_s3
    always_ff @(posedge clk) begin
      if (en) begin
        s3_dn_r[k] <= sat32(50'(s2_pd_r[k][0]) + 50'(s2_pd_r[k][1]) + 50'(s2_pd_r[k][2]));
        s3_dc_r[k] <= sat32(50'(s2_pc_r[k][0]) + 50'(s2_pc_r[k][1]) + 50'(s2_pc_r[k][2]));
      end
    end
  end

  // Plane offsets, parallel tests and the divider feed. Each axis gets two
  // dividers, one per face.
  sb_t                sb_nxt;
  logic signed [31:0] q [3][2];
  logic signed [33:0] neg_eps;

  assign neg_eps = -$signed({18'd0, eps_r});

  for (genvar k = 0; k < 3; k++) begin : g_ax
    logic signed [33:0] f1;
    logic signed [33:0] f2;
    logic [33:0]        f1_abs;
    logic [33:0]        f2_abs;
    logic [31:0]        dn_abs;

    assign f1     = 34'sd65536 - 34'(s3_dc_r[k]);
    assign f2     = -34'sd65536 - 34'(s3_dc_r[k]);
    assign f1_abs = f1[33] ? 34'(-f1) : 34'(f1);
    assign f2_abs = f2[33] ? 34'(-f2) : 34'(f2);
    assign dn_abs = s3_dn_r[k][31] ? 32'(-s3_dn_r[k]) : 32'(s3_dn_r[k]);

    assign sb_nxt.np[k]     = dn_abs > {16'd0, eps_r};
    assign sb_nxt.pmiss[k]  = (f1 < neg_eps) || (f2 > $signed({18'd0, eps_r}));
    assign sb_nxt.pundef[k] = (f1_abs <= {18'd0, eps_r}) || (f2_abs <= {18'd0, eps_r});

    obb_div u_div_near (
      .clk     (clk),
      .en      (en),
      .num_neg (f1[33]),
      .num_mag ({f1_abs[31:0], 16'd0}),
      .den_neg (s3_dn_r[k][31]),
      .den_mag (dn_abs),
      .quo     (q[k][0])
    );

    obb_div u_div_far (
      .clk     (clk),
      .en      (en),
      .num_neg (f2[33]),
      .num_mag ({f2_abs[31:0], 16'd0}),
      .den_neg (s3_dn_r[k][31]),
      .den_mag (dn_abs),
      .quo     (q[k][1])
    );
  end

  assign sb_nxt.v = s3_v_r;

  // Side line that keeps the per-box flags aligned with the quotients.
  sb_t sb_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        sb_r[i] <= '0;
      end
    end else if (en) begin
      sb_r[0] <= sb_nxt;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // Stage P1: order each axis pair so that lo <= hi.
  sb_t                p1_sb_r;
  logic signed [31:0] p1_lo_r [3];
  logic signed [31:0] p1_hi_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_sb_r <= '0;
    end else if (en) begin
      p1_sb_r <= sb_r[DIV_LAT-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_p1
    always_ff @(posedge clk) begin
      if (en) begin
        p1_lo_r[k] <= (q[k][0] > q[k][1]) ? q[k][1] : q[k][0];
        p1_hi_r[k] <= (q[k][0] > q[k][1]) ? q[k][0] : q[k][1];
      end
    end
  end

  // Final stage: walk the axes in order, narrowing the entry and exit
  // bounds. The first axis that misses or lies on a face settles the kind.
  kind_t              kind_nxt;
  logic signed [31:0] dist_nxt;

  always_comb begin
    logic signed [31:0] ent;
    logic signed [31:0] ext;
    logic               done;
    ent      = -FAR_BOUND;
    ext      = FAR_BOUND;
    done     = 1'b0;
    kind_nxt = KIND_HIT;
    for (int k = 0; k < 3; k++) begin
      if (!done) begin
        if (p1_sb_r.np[k]) begin
          if (p1_lo_r[k] > ent) begin
            ent = p1_lo_r[k];
          end
          if (p1_hi_r[k] < ext) begin
            ext = p1_hi_r[k];
          end
          if (ent > ext) begin
            kind_nxt = KIND_MISS;
            done     = 1'b1;
          end
        end else if (p1_sb_r.pmiss[k]) begin
          kind_nxt = KIND_MISS;
          done     = 1'b1;
        end else if (p1_sb_r.pundef[k]) begin
          kind_nxt = KIND_UNDEF;
          done     = 1'b1;
        end
      end
    end
    dist_nxt = (kind_nxt == KIND_HIT) ? ent : '0;
  end

  kind_t              out_kind_r;
  logic signed [31:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p1_sb_r.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r <= kind_nxt;
      out_dist_r <= dist_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit_kind     = out_kind_r;
  assign out_hit_distance = out_dist_r;

  // A result word never carries the unused kind code.
  a_kind_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == KIND_HIT || out_kind_r == KIND_MISS ||
                     out_kind_r == KIND_UNDEF))
    else $error("illegal hit kind on output");

  // Anything but a hit reports a zero distance.
  a_dist_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_HIT) |-> out_dist_r == '0)
    else $error("non-zero distance on a miss or undefined result");

  // A hit's entry distance lies within the far bounds.
  a_dist_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_HIT) |->
      (out_dist_r >= -FAR_BOUND && out_dist_r <= FAR_BOUND))
    else $error("hit distance outside the far bounds");

  // A word taken at the input reaches stage one on the next edge.
  a_enter : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r)
    else $error("accepted box word lost at pipeline entry");

endmodule
`default_nettype wire

// File: verif/tb_ray_oriented_box_slab_test_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray against oriented box slab test core testbench
// Streams box words through the core under several ray settings, predicts
// each result word from an independent fixed point slab test and compares
// the words in order, with random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
module tb_ray_oriented_box_slab_test_core;
  import obb_pkg::*;

  localparam int LATENCY = 55;

  typedef struct {
    logic signed [31:0] v[12];
  } box_t;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] distance;
  } slab_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_f[12];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_hit_kind;
  logic signed [31:0] out_hit_distance;

  // Our own copy of the ray registers.
  longint ray_org[3];
  longint ray_dir[3];
  longint ray_eps;

  slab_result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int hits = 0, misses = 0, undefs = 0;
  bit idle_enable = 1'b1;
  int hold_off = 0;

  initial begin
    for (int i = 0; i < 12; i++) in_f[i] = '0;
  end

  always #6 clk = ~clk;

  ray_oriented_box_slab_test_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_center_x(in_f[0]), .in_center_y(in_f[1]), .in_center_z(in_f[2]),
    .in_axis0_x(in_f[3]), .in_axis0_y(in_f[4]), .in_axis0_z(in_f[5]),
    .in_axis1_x(in_f[6]), .in_axis1_y(in_f[7]), .in_axis1_z(in_f[8]),
    .in_axis2_x(in_f[9]), .in_axis2_y(in_f[10]), .in_axis2_z(in_f[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit_kind(out_hit_kind), .out_hit_distance(out_hit_distance)
  );

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Product scaled back to Q16.16, rounded towards minus infinity.
  function automatic longint fx_dot3(longint a[3], longint n[3]);
    longint s;
    s = 0;
    for (int c = 0; c < 3; c++) s += (a[c] * n[c]) >>> 16;
    return clamp32(s);
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  // The slab test over the three box axes in order; the first miss or face
  // contact ends it.
  function automatic slab_result_t predict_slab(box_t b);
    slab_result_t r;
    longint rc[3], ax[3];
    longint near_t, far_t, dn, dc, f1, f2, t1, t2, tmp;
    kind_t kind;
    near_t = -64'sd655360000;
    far_t = 64'sd655360000;
    kind = KIND_HIT;
    for (int c = 0; c < 3; c++) rc[c] = clamp32(ray_org[c] - longint'(b.v[c]));
    for (int k = 0; k < 3; k++) begin
      if (kind == KIND_HIT) begin
        for (int c = 0; c < 3; c++) ax[c] = longint'(b.v[3 + 3 * k + c]);
        dn = fx_dot3(ray_dir, ax);
        dc = fx_dot3(rc, ax);
        f1 = 65536 - dc;
        f2 = -65536 - dc;
        if (abs_l(dn) > ray_eps) begin
          t1 = clamp32((f1 * 65536) / dn);
          t2 = clamp32((f2 * 65536) / dn);
          if (t1 > t2) begin
            tmp = t1; t1 = t2; t2 = tmp;
          end
          if (t1 > near_t) near_t = t1;
          if (t2 < far_t) far_t = t2;
          if (near_t > far_t) kind = KIND_MISS;
        end else if (f1 < -ray_eps || f2 > ray_eps) begin
          kind = KIND_MISS;
        end else if (abs_l(f1) <= ray_eps || abs_l(f2) <= ray_eps) begin
          kind = KIND_UNDEF;
        end
      end
    end
    r.kind = kind;
    r.distance = (kind == KIND_HIT) ? near_t[31:0] : 32'sd0;
    return r;
  endfunction

  function automatic bit roll_idle();
    return idle_enable && ($urandom_range(99) < 21);
  endfunction

  // Registers are only written while nothing is in flight.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < REG_DIRECTION_X) ray_org[idx] = longint'($signed(value));
    else if (idx < REG_EPSILON) ray_dir[idx - 3] = longint'($signed(value));
    else ray_eps = longint'(value[15:0]);
  endtask

  task automatic set_ray(logic [31:0] o[3], logic [31:0] d[3], logic [15:0] e);
    for (int c = 0; c < 3; c++) write_reg(reg_idx_t'(c), o[c]);
    for (int c = 0; c < 3; c++) write_reg(reg_idx_t'(c + 3), d[c]);
    write_reg(REG_EPSILON, {16'd0, e});
  endtask

  // Offers one box word and holds it until the core takes it. Valid stays
  // high after the hand-over so that words can follow back to back; it drops
  // only while the sender idles or drains.
  task automatic send_box(box_t b);
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 12; i++) in_f[i] <= b.v[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_slab(b));
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Result side: random stalls, plus the long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !roll_idle();
    end
  end

  always @(posedge clk) begin
    slab_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        case (exp_r.kind)
          KIND_HIT: hits++;
          KIND_MISS: misses++;
          default: undefs++;
        endcase
        if (out_hit_kind !== exp_r.kind) begin
          $error("hit_kind expected %0d actual %0d", exp_r.kind, out_hit_kind);
          errors++;
        end
        if (out_hit_distance !== exp_r.distance) begin
          $error("hit_distance expected %0d actual %0d", exp_r.distance,
                 out_hit_distance);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rnd_edge32();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // A box of modest size near the ray, so most boxes take the full test.
  function automatic box_t rnd_box();
    box_t b;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 12; i++) begin
      if (mode == 0) b.v[i] = rnd_edge32();
      else if (mode == 1) b.v[i] = $urandom();
      else if (i < 3) b.v[i] = $signed($urandom_range(2 * 655360)) - 655360;
      else b.v[i] = $signed($urandom_range(131072)) - 65536;
    end
    // Sometimes axis-aligned with the ray so the parallel paths are taken.
    if (mode == 2) begin
      for (int k = 0; k < 3; k++) b.v[3 + 3 * k + 2] = 0;
    end
    return b;
  endfunction

  function automatic box_t unit_box(logic signed [31:0] cx, logic signed [31:0] cy,
                                    logic signed [31:0] cz);
    box_t b;
    for (int i = 0; i < 12; i++) b.v[i] = 0;
    b.v[0] = cx; b.v[1] = cy; b.v[2] = cz;
    b.v[3] = FX_ONE; b.v[7] = FX_ONE; b.v[11] = FX_ONE;
    return b;
  endfunction

  // Straight ahead, off to the side, on a face, behind, inside, all-extreme and all-zero fields, then odd ray settings.
  task automatic test_directed();
    box_t b;
    logic [31:0] o[3], d[3];
    send_box(unit_box(0, 0, 32'sd327680));       // hit ahead
    send_box(unit_box(32'sd327680, 0, 0));       // parallel, outside
    send_box(unit_box(FX_ONE, 0, 32'sd327680));  // ray on a face
    send_box(unit_box(0, 0, -32'sd327680));      // box behind the ray
    send_box(unit_box(0, 0, 0));                 // origin inside
    b = unit_box(0, 0, 0);
    for (int i = 0; i < 12; i++) b.v[i] = 32'h8000_0000;
    send_box(b);
    for (int i = 0; i < 12; i++) b.v[i] = 32'h7FFF_FFFF;
    send_box(b);
    for (int i = 0; i < 12; i++) b.v[i] = 0;     // all axes parallel, inside-ish
    send_box(b);
    drain();
    // Zero direction with zero tolerance: every axis parallel, no division.
    o = '{0, 0, 0}; d = '{0, 0, 0};
    set_ray(o, d, 16'd0);
    send_box(unit_box(0, 0, 0));
    send_box(unit_box(FX_ONE, 0, 0));
    send_box(unit_box(32'sd200000, 0, 0));
    drain();
    // Extreme origin and direction, widest tolerance.
    o = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    set_ray(o, d, 16'hFFFF);
    send_box(unit_box(0, 0, 0));
    send_box(unit_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    b = unit_box(0, 0, 0);
    for (int i = 0; i < 12; i++) b.v[i] = 32'h8000_0000;
    send_box(b);
    drain();
    // An out-of-range register index must be ignored.
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= 3'd7; cfg_data <= 32'hDEAD_BEEF;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_box(unit_box(0, 0, 0));
    drain();
  endtask

  task automatic test_random(int count, bit quiet);
    logic [31:0] o[3], d[3];
    idle_enable = !quiet;
    for (int c = 0; c < 3; c++) begin
      o[c] = ($urandom_range(3) == 0) ? rnd_edge32()
                                      : $signed($urandom_range(262144)) - 131072;
      d[c] = ($urandom_range(3) == 0) ? rnd_edge32()
                                      : $signed($urandom_range(131072)) - 65536;
    end
    set_ray(o, d, ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(200)));
    for (int n = 0; n < count; n++) send_box(rnd_box());
    drain();
    idle_enable = 1'b1;
  endtask

  // The receiver stops for a long stretch so the pipeline fills up.
  task automatic test_backpressure();
    @(posedge clk);
    hold_off <= 300;
    for (int n = 0; n < 150; n++) send_box(rnd_box());
    drain();
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, 65536};
    ray_eps = 66;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 8; p++) test_random(180, p == 3);
    test_backpressure();
    test_random(200, 1'b0);
    $display("Covered %0d boxes over several ray settings: %0d hits, %0d misses, %0d undefined.",
             words_sent, hits, misses, undefs);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** ray_oriented_box_slab_test_core: PASSED **");
    end else begin
      $display("** ray_oriented_box_slab_test_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** ray_oriented_box_slab_test_core: FAILED **");
    $finish;
  end

endmodule
